// ===== rtl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;

    localparam logic [15:0] CP_TWO   = 16'h0080;
    localparam logic [15:0] CP_THREE = 16'h0800;

    // all output bytes caused by one input word, byte 0 goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      str_end;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/json_string_unescape_utf8_unit.sv =====
`default_nettype none

// JSON string unescaper: takes one raw string-body byte per word and gives the
// unescaped bytes one per word, with \u escapes turned into 1 to 3 UTF-8
// bytes and broken escapes given back literally. An input word is taken every
// cycle while the queue between the decoder and the output serializer has
// room; a word that expands into n bytes is sent out as n output bytes, so
// long expansions fill the QUEUE_DEPTH-entry queue and then stall the input.
// Bytes inside an escape produce nothing until it completes. A byte passes
// through the queue, the current-word register and the output register on
// its way to m_tdata. m_tlast marks the last byte caused by one input word,
// m_tuser the last byte of the whole string.
module json_string_unescape_utf8_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [7:0] in_byte
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] string_done
);

    logic            accept;
    logic            push;
    logic            full;
    logic            q_valid;
    logic            pop;
    jsu_pkg::entry_t push_data;
    jsu_pkg::entry_t pop_data;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .str_end (s_tlast),
        .push    (push),
        .entry   (push_data)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (pop_data)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/jsu_queue.sv =====
`default_nettype none

`include "assert_macros.svh"

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  jsu_pkg::entry_t  push_data,
    output logic             full,
    input  wire              pop,
    output logic             not_empty,
    output jsu_pkg::entry_t  pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, push, !full)
    `ASSERT_IMPLIES(a_empty_ptrs, aclk, aresetn, count_reg == '0, rd_ptr_reg == wr_ptr_reg)

endmodule

`default_nettype wire

// ===== rtl/jsu_front.sv =====
`default_nettype none

`include "assert_macros.svh"

module jsu_front (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              accept,
    input  wire [7:0]        in_byte,
    input  wire              str_end,
    output logic             push,
    output jsu_pkg::entry_t  entry
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_U0   = 3'd2,
        PH_U1   = 3'd3,
        PH_U2   = 3'd4,
        PH_U3   = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg [3];

    logic        plain_emit;
    logic        hex_ok;
    logic        hold_wr;
    logic [1:0]  hold_idx;
    logic [2:0]  flush_n;
    logic [7:0]  held_list [jsu_pkg::MAX_BYTES];
    logic [15:0] cp;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // simple escape letters, ok low when the letter is not one
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        case (c)
            8'h22:   return {1'b1, 8'h22};
            8'h5C:   return {1'b1, 8'h5C};
            8'h2F:   return {1'b1, 8'h2F};
            8'h62:   return {1'b1, 8'h08};
            8'h66:   return {1'b1, 8'h0C};
            8'h6E:   return {1'b1, 8'h0A};
            8'h72:   return {1'b1, 8'h0D};
            8'h74:   return {1'b1, 8'h09};
            default: return {1'b0, 8'h00};
        endcase
    endfunction

    logic [8:0] esc;

    always_comb begin
        held_list[0] = jsu_pkg::CHAR_BSLASH;
        held_list[1] = jsu_pkg::CHAR_U;
        held_list[2] = held_reg[0];
        held_list[3] = held_reg[1];
        held_list[4] = held_reg[2];
        held_list[5] = in_byte;

        plain_emit = !(in_byte == jsu_pkg::CHAR_BSLASH && !str_end);
        hex_ok     = is_hex(in_byte);
        esc        = simple_esc(in_byte);
        flush_n    = phase_reg;
        cp         = {hex_nib(held_reg[0]), hex_nib(held_reg[1]),
                      hex_nib(held_reg[2]), hex_nib(in_byte)};

        entry         = '0;
        entry.str_end = str_end;
        phase_next    = PH_IDLE;
        hold_wr       = 1'b0;
        hold_idx      = 2'(phase_reg - 3'd2);

        unique case (phase_reg)
            PH_IDLE: begin
                entry.bytes[0] = in_byte;
                entry.cnt      = jsu_pkg::CNT_W'(plain_emit);
                if (!plain_emit) begin
                    phase_next = PH_ESC;
                end
            end
            default: begin
                if (phase_reg == PH_ESC && esc[8]) begin
                    entry.bytes[0] = esc[7:0];
                    entry.cnt      = 3'd1;
                end else if (phase_reg == PH_ESC && in_byte == jsu_pkg::CHAR_U && !str_end) begin
                    phase_next = PH_U0;
                end else if (phase_reg == PH_U3 && hex_ok) begin
                    if (cp < jsu_pkg::CP_TWO) begin
                        entry.bytes[0] = cp[7:0];
                        entry.cnt      = 3'd1;
                    end else if (cp < jsu_pkg::CP_THREE) begin
                        entry.bytes[0] = {3'b110, cp[10:6]};
                        entry.bytes[1] = {2'b10, cp[5:0]};
                        entry.cnt      = 3'd2;
                    end else begin
                        entry.bytes[0] = {4'b1110, cp[15:12]};
                        entry.bytes[1] = {2'b10, cp[11:6]};
                        entry.bytes[2] = {2'b10, cp[5:0]};
                        entry.cnt      = 3'd3;
                    end
                end else if (phase_reg != PH_ESC && hex_ok && !str_end) begin
                    hold_wr    = 1'b1;
                    phase_next = phase_t'(phase_reg + 3'd1);
                end else begin
                    // give back the held bytes, then treat the byte as plain
                    for (int i = 0; i < jsu_pkg::MAX_BYTES; i++) begin
                        if (3'(i) < flush_n) begin
                            entry.bytes[i] = held_list[i];
                        end else begin
                            entry.bytes[i] = in_byte;
                        end
                    end
                    entry.cnt = flush_n + 3'(plain_emit);
                    if (!plain_emit) begin
                        phase_next = PH_ESC;
                    end
                end
            end
        endcase

        if (str_end) begin
            phase_next = PH_IDLE;
        end

        push = accept && (entry.cnt != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hold_wr) begin
            held_reg[hold_idx] <= in_byte;
        end
    end

    `ASSERT_IMPLIES(a_end_gives_word, aclk, aresetn, accept && str_end, push)
    `ASSERT_NEXT(a_end_clears_phase, aclk, aresetn, accept && str_end, phase_reg == PH_IDLE)

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module jsu_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              q_valid,
    input  jsu_pkg::entry_t  q_data,
    output logic             pop,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic [jsu_pkg::MAX_BYTES-1:0][7:0] cur_bytes_reg;
    logic [jsu_pkg::CNT_W-1:0]          cur_cnt_reg;
    logic                               cur_end_reg;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic out_free;
    logic take;
    logic last_byte;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign take      = out_free && (cur_cnt_reg != '0);
    assign last_byte = (cur_cnt_reg == 3'd1);
    // refill the current word when it is empty or as its last byte leaves
    assign pop       = q_valid && ((cur_cnt_reg == '0) || (take && last_byte));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (pop) begin
                cur_cnt_reg <= q_data.cnt;
            end else if (take) begin
                cur_cnt_reg <= cur_cnt_reg - 1'b1;
            end
            if (take) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_bytes_reg <= q_data.bytes;
            cur_end_reg   <= q_data.str_end;
        end else if (take) begin
            cur_bytes_reg <= {8'h00, cur_bytes_reg[jsu_pkg::MAX_BYTES-1:1]};
        end
        if (take) begin
            m_tdata_reg <= cur_bytes_reg[0];
            m_tlast_reg <= last_byte;
            m_tuser_reg <= last_byte && cur_end_reg;
        end
    end

    `ASSERT_NEXT(a_take_shows, aclk, aresetn, take, m_tvalid_reg)
    `ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cur_cnt_reg <= 3'd6)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // escape tracking, same encoding as the block's phase
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ESC  = 3'd1;
    localparam logic [2:0] PH_U    = 3'd2;
    localparam logic [2:0] PH_HEX1 = 3'd3;
    localparam logic [2:0] PH_HEX2 = 3'd4;
    localparam logic [2:0] PH_HEX3 = 3'd5;

    localparam logic [7:0] ESC_CHARS [8] = '{8'h22, 8'h5C, 8'h2F, "b", "f", "n", "r", "t"};
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [7:0] b;
        logic       run_last;
        logic       done;
    } out_word_t;

    // typed_n < 0: take the expectation from the predictor
    typedef struct {
        logic [7:0]  b;
        logic        last;
        int          typed_n;
        logic [23:0] typed;
    } row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tlast;
    wire        m_tuser;

    json_string_unescape_utf8_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    int err_count   = 0;
    int tx_idle_pct = 29;
    int rx_idle_pct = 45;
    int rx_hold_req = 0;

    logic [2:0] esc_phase = PH_IDLE;
    logic [7:0] held_hex [3];
    logic [7:0] run_bytes [$];
    logic [7:0] str_bytes [$];
    out_word_t  owed_bytes [$];

    row_t directed [26] = '{
        '{"A",   1'b0, 1, 24'h41},
        '{8'hFF, 1'b1, 1, 24'hFF},
        '{8'h5C, 1'b0, 0, 24'h0},
        '{"x",   1'b0, 2, 24'h5C78},      // unknown escape
        '{8'h5C, 1'b0, 0, 24'h0},
        '{"n",   1'b0, 1, 24'h0A},
        '{8'h5C, 1'b0, 0, 24'h0},
        '{"u",   1'b0, 0, 24'h0},
        '{"0",   1'b0, 0, 24'h0},
        '{"0",   1'b0, 0, 24'h0},
        '{"0",   1'b0, 0, 24'h0},
        '{"0",   1'b0, 1, 24'h00},        // code point zero still gives a byte
        '{8'h5C, 1'b0, 0, 24'h0},
        '{"u",   1'b0, 0, 24'h0},
        '{"F",   1'b0, 0, 24'h0},
        '{"f",   1'b0, 0, 24'h0},
        '{"F",   1'b0, 0, 24'h0},
        '{"f",   1'b0, 3, 24'hEFBFBF},
        '{8'h5C, 1'b0, 0, 24'h0},
        '{"u",   1'b0, 0, 24'h0},
        '{"7",   1'b0, 0, 24'h0},
        '{"g",   1'b0, -1, 24'h0},        // bad hex digit
        '{8'h5C, 1'b0, 0, 24'h0},
        '{"u",   1'b0, 0, 24'h0},
        '{"1",   1'b1, 3, 24'h5C7531},    // string ends inside the escape
        '{8'h5C, 1'b1, 1, 24'h5C}         // lone final backslash
    };

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    function automatic int simple_char(input logic [7:0] c);
        case (c)
            8'h22, 8'h5C, 8'h2F: return int'(c);
            "b": return 8'h08;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            default: return -1;
        endcase
    endfunction

    function automatic void take_plain(input logic [7:0] c, input logic last);
        if (c == jsu_pkg::CHAR_BSLASH && !last) begin
            esc_phase = PH_ESC;
        end else begin
            run_bytes.push_back(c);
        end
    endfunction

    // broken escape: the held bytes go out as they came in
    function automatic void give_back(input logic [2:0] ph);
        run_bytes.push_back(jsu_pkg::CHAR_BSLASH);
        if (ph >= PH_U) begin
            run_bytes.push_back(jsu_pkg::CHAR_U);
            for (int i = 0; i + 2 < ph; i++) run_bytes.push_back(held_hex[i]);
        end
    endfunction

    function automatic void unescape_byte(input logic [7:0] c, input logic last);
        logic [2:0]  ph;
        logic [4:0]  d;
        logic [4:0]  h0;
        logic [4:0]  h1;
        logic [4:0]  h2;
        logic [15:0] cp;
        int          m;
        ph = esc_phase;
        if (ph > PH_HEX3) ph = PH_IDLE;
        esc_phase = PH_IDLE;
        run_bytes.delete();
        if (ph == PH_IDLE) begin
            take_plain(c, last);
        end else if (ph == PH_ESC) begin
            m = simple_char(c);
            if (m >= 0) begin
                run_bytes.push_back(m[7:0]);
            end else if (c == jsu_pkg::CHAR_U && !last) begin
                esc_phase = PH_U;
            end else begin
                give_back(ph);
                take_plain(c, last);
            end
        end else begin
            d = hex_digit(c);
            if (d[4] && ph == PH_HEX3) begin
                h0 = hex_digit(held_hex[0]);
                h1 = hex_digit(held_hex[1]);
                h2 = hex_digit(held_hex[2]);
                cp = {h0[3:0], h1[3:0], h2[3:0], d[3:0]};
                if (cp < jsu_pkg::CP_TWO) begin
                    run_bytes.push_back(cp[7:0]);
                end else if (cp < jsu_pkg::CP_THREE) begin
                    run_bytes.push_back({3'b110, cp[10:6]});
                    run_bytes.push_back({2'b10, cp[5:0]});
                end else begin
                    run_bytes.push_back({4'b1110, cp[15:12]});
                    run_bytes.push_back({2'b10, cp[11:6]});
                    run_bytes.push_back({2'b10, cp[5:0]});
                end
            end else if (d[4] && !last) begin
                held_hex[2'(ph - PH_U)] = c;
                esc_phase = ph + 3'd1;
            end else begin
                give_back(ph);
                take_plain(c, last);
            end
        end
        if (last) esc_phase = PH_IDLE;
    endfunction

    task automatic send_word(input logic [7:0] c, input logic last, input int typed_n,
                             input logic [23:0] typed);
        int gap;
        int n;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        unescape_byte(c, last);
        if (typed_n >= 0) begin
            run_bytes.delete();
            for (int i = 0; i < typed_n; i++) run_bytes.push_back(typed[8*(typed_n-1-i) +: 8]);
        end
        n = run_bytes.size();
        for (int i = 0; i < n; i++)
            owed_bytes.push_back('{run_bytes[i], i == n - 1, (i == n - 1) && last});
    endtask

    // sender goes quiet until every owed byte has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_bytes.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // well-formed escapes, some broken ones and raw noise
    task automatic build_string();
        int          ntok;
        int          kind;
        int          k;
        logic [15:0] cp;
        logic [7:0]  b;
        str_bytes.delete();
        ntok = $urandom_range(1, 8);
        repeat (ntok) begin
            kind = $urandom_range(9);
            if (kind <= 3) begin
                str_bytes.push_back(8'($urandom_range(255)));
            end else if (kind <= 5) begin
                str_bytes.push_back(jsu_pkg::CHAR_BSLASH);
                str_bytes.push_back(ESC_CHARS[3'($urandom_range(7))]);
            end else if (kind <= 7) begin
                case ($urandom_range(2))
                    0: cp = 16'($urandom_range(16'h007F));
                    1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
                    default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                endcase
                str_bytes.push_back(jsu_pkg::CHAR_BSLASH);
                str_bytes.push_back(jsu_pkg::CHAR_U);
                for (int i = 3; i >= 0; i--)
                    str_bytes.push_back(hex_char(cp[4*i +: 4], 1'($urandom_range(1))));
            end else if (kind == 8) begin
                str_bytes.push_back(jsu_pkg::CHAR_BSLASH);
                str_bytes.push_back(8'($urandom_range(255)));
            end else begin
                str_bytes.push_back(jsu_pkg::CHAR_BSLASH);
                str_bytes.push_back(jsu_pkg::CHAR_U);
                k = $urandom_range(3);
                repeat (k)
                    str_bytes.push_back(hex_char(4'($urandom_range(15)),
                                                 1'($urandom_range(1))));
                do b = 8'($urandom_range(255)); while (hex_digit(b) != 5'd0);
                str_bytes.push_back(b);
            end
        end
        // cut the tail now and then so the string may end inside an escape
        if ($urandom_range(5) == 0 && str_bytes.size() > 2) begin
            k = $urandom_range(1, 2);
            repeat (k) void'(str_bytes.pop_back());
        end
    endtask

    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_out
        out_word_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (owed_bytes.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h last %b done %b",
                         $time, m_tdata, m_tlast, m_tuser);
                err_count++;
            end else begin
                want = owed_bytes.pop_front();
                if (m_tdata !== want.b) begin
                    $display("%0t: byte mismatch, expected %h, got %h", $time, want.b, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.run_last) begin
                    $display("%0t: run_last mismatch, expected %b, got %b",
                             $time, want.run_last, m_tlast);
                    err_count++;
                end
                if (m_tuser !== want.done) begin
                    $display("%0t: string_done mismatch, expected %b, got %b",
                             $time, want.done, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    initial begin : stimulus
        int sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].b, directed[i].last, directed[i].typed_n, directed[i].typed);

        for (int pass = 0; pass < 3; pass++) begin
            wait_drained();
            case (pass)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 45;
                    rx_hold_req = 80;   // long receiver stall to back up the queue
                end
                1: begin
                    tx_idle_pct = 45;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 50) begin
                build_string();
                foreach (str_bytes[i])
                    send_word(str_bytes[i], i == str_bytes.size() - 1, -1, 24'h0);
                sent += str_bytes.size();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
